// ===== rtl/ilu_pkg.sv =====
package ilu_pkg;

  localparam int MaxRows    = 1024;
  localparam int MaxEntries = 8192;
  localparam int FracBits   = 24;
  localparam int RowW       = $clog2(MaxRows);
  localparam int EntW       = $clog2(MaxEntries);

  localparam logic [2:0] OpWrStruct = 3'd0;
  localparam logic [2:0] OpWrFactor = 3'd1;
  localparam logic [2:0] OpWrRhs    = 3'd2;
  localparam logic [2:0] OpStart    = 3'd3;
  localparam logic [2:0] OpRead     = 3'd4;

  localparam logic [1:0] ModeFwd = 2'd1;
  localparam logic [1:0] ModeBwd = 2'd2;

  localparam logic CfgSweepMode = 1'b0;
  localparam logic CfgRowCount  = 1'b1;

  typedef struct packed {
    logic [2:0]         operation;
    logic [12:0]        addr;
    logic [12:0]        index_word;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               status;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== rtl/ilu_ram.sv =====
module ilu_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/ilu_mac.sv =====
// acc - a*b (or a*b alone when sub_i is low), floor-shifted product, saturated;
// one register stage, result valid the cycle after the inputs.
module ilu_mac (
  input  logic               clk_i,
  input  logic signed [31:0] acc_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic               sub_i,
  output logic signed [31:0] res_o
);
  import ilu_pkg::*;
  logic signed [63:0] prod_q;
  logic signed [31:0] acc_q;
  logic               sub_q;
  logic signed [63:0] sh;
  logic signed [31:0] pq;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    acc_q  <= acc_i;
    sub_q  <= sub_i;
  end

  always_comb begin
    sh = prod_q >>> FracBits;
    pq = sat32(sh);
    if (sub_q) res_o = sat32(64'(acc_q) - 64'(pq));
    else       res_o = pq;
  end
endmodule

// ===== rtl/ilu_sparse_triangular_solve.sv =====
// Sparse ILU triangular solve engine. An item is accepted only while idle
// and no result waits; a read item adds a synchronous memory read. A start
// item holds the input channel through every sweep: each entry step is a
// structure read, a factor/vector read and a registered multiply-subtract,
// done one at a time on single-read-port memories. Single-sweep modes add a
// copy pass over the rows.
// Arithmetic is Q8.24, floor-truncated products, saturating subtracts.
// Memories are not cleared at reset; unwritten entries read undefined.
module ilu_sparse_triangular_solve (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ilu_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ilu_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import ilu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_ROW, S_PTR1, S_PTR2, S_ENT, S_ENT2, S_ENT3,
    S_MAC1, S_MAC2, S_DIAG, S_DIAG2, S_COPY, S_COPY2, S_DONE
  } state_e;

  state_e state_q;
  logic [1:0]  mode_q;
  logic [10:0] rows_q;
  logic        bwd_q;
  logic [RowW:0] i_q;
  logic [EntW:0] lo_q, hi_q, j_q;
  logic signed [31:0] acc_q, fv_q, dv_q;
  logic [12:0] col_q;
  logic        copy_q;

  logic [10:0] m;
  assign m = (rows_q > 11'(MaxRows)) ? 11'(MaxRows) : rows_q;

  logic           s_we;  logic [EntW-1:0] s_ra; logic [12:0] s_rd;
  logic           f_we;  logic [EntW-1:0] f_ra; logic [31:0] f_rd;
  logic           r_we;  logic [RowW-1:0] r_ra; logic [31:0] r_rd;
  logic           mv_we; logic [RowW-1:0] mv_wa, mv_ra; logic [31:0] mv_wd, mv_rd;
  logic           sv_we; logic [RowW-1:0] sv_wa, sv_ra; logic [31:0] sv_wd, sv_rd;
  logic signed [31:0] mac_acc, mac_a, mac_b, mac_res;
  logic mac_sub;

  logic in_fire;
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_o;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign s_we = in_fire && in_data_i.operation == OpWrStruct;
  assign f_we = in_fire && in_data_i.operation == OpWrFactor;
  assign r_we = in_fire && in_data_i.operation == OpWrRhs && in_data_i.addr < 13'(MaxRows);

  ilu_ram #(.Width(13), .Depth(MaxEntries)) u_struct (.clk_i, .we_i(s_we),
    .waddr_i(in_data_i.addr[EntW-1:0]), .wdata_i(in_data_i.index_word),
    .raddr_i(s_ra), .rdata_o(s_rd));
  ilu_ram #(.Width(32), .Depth(MaxEntries)) u_factor (.clk_i, .we_i(f_we),
    .waddr_i(in_data_i.addr[EntW-1:0]), .wdata_i(in_data_i.value),
    .raddr_i(f_ra), .rdata_o(f_rd));
  ilu_ram #(.Width(32), .Depth(MaxRows)) u_rhs (.clk_i, .we_i(r_we),
    .waddr_i(in_data_i.addr[RowW-1:0]), .wdata_i(in_data_i.value),
    .raddr_i(r_ra), .rdata_o(r_rd));
  ilu_ram #(.Width(32), .Depth(MaxRows)) u_mid (.clk_i, .we_i(mv_we),
    .waddr_i(mv_wa), .wdata_i(mv_wd), .raddr_i(mv_ra), .rdata_o(mv_rd));
  ilu_ram #(.Width(32), .Depth(MaxRows)) u_sol (.clk_i, .we_i(sv_we),
    .waddr_i(sv_wa), .wdata_i(sv_wd), .raddr_i(sv_ra), .rdata_o(sv_rd));

  ilu_mac u_mac (.clk_i, .acc_i(mac_acc), .a_i(mac_a), .b_i(mac_b),
    .sub_i(mac_sub), .res_o(mac_res));

  logic [EntW:0] ent_cur;
  logic [EntW:0] ptr_rd;
  assign ent_cur = bwd_q ? (j_q - 1'b1) : j_q;
  assign ptr_rd  = {1'b0, s_rd[EntW-1:0]};
  logic [RowW-1:0] ir;
  assign ir = i_q[RowW-1:0];

  always_comb begin
    s_ra = ent_cur[EntW-1:0];
    f_ra = ent_cur[EntW-1:0];
    r_ra = ir;
    mv_ra = bwd_q ? ir : col_q[RowW-1:0];
    sv_ra = in_data_i.addr[RowW-1:0];
    mv_we = 1'b0; mv_wa = ir; mv_wd = acc_q;
    sv_we = 1'b0; sv_wa = ir; sv_wd = mac_res;
    mac_acc = acc_q; mac_a = fv_q; mac_b = bwd_q ? sv_rd : mv_rd; mac_sub = 1'b1;
    case (state_q)
      S_ROW:  begin s_ra = EntW'(ir); f_ra = EntW'(ir); end
      S_PTR1: s_ra = EntW'(i_q + 1'b1);
      S_ENT2: begin mv_ra = s_rd[RowW-1:0]; sv_ra = s_rd[RowW-1:0]; end
      S_MAC1: begin if (bwd_q) sv_ra = col_q[RowW-1:0]; end
      S_DIAG: begin mac_a = acc_q; mac_b = dv_q; mac_sub = 1'b0;
                    mv_we = 1'b1; end
      S_DIAG2: sv_we = bwd_q;
      S_COPY:  begin mv_ra = ir; end
      S_COPY2: begin
        if (copy_q) begin sv_we = 1'b1; sv_wd = mv_rd; end
        else begin mv_we = 1'b1; mv_wd = r_rd; end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; mode_q <= 2'd0; rows_q <= 11'd1; bwd_q <= 1'b0;
      out_valid_o <= 1'b0; copy_q <= 1'b0; i_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgSweepMode) mode_q <= cfg_data_i[1:0];
        else rows_q <= cfg_data_i[10:0];
      end
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: if (in_fire) begin
          out_data_o.read_value <= '0;
          out_data_o.status <= 1'b0;
          if (in_data_i.operation == OpRead && in_data_i.addr < 13'(MaxRows))
            state_q <= S_READ;
          else if (in_data_i.operation == OpStart) begin
            if (m == 0) begin out_data_o.status <= 1'b1; out_valid_o <= 1'b1; end
            else if (mode_q == ModeBwd) begin
              copy_q <= 1'b0; i_q <= '0; state_q <= S_COPY;
            end else begin
              bwd_q <= 1'b0; i_q <= '0; state_q <= S_ROW;
            end
          end else out_valid_o <= 1'b1;
        end
        S_READ: begin
          out_data_o.read_value <= sv_rd; out_valid_o <= 1'b1; state_q <= S_IDLE;
        end
        S_ROW: state_q <= S_PTR1;
        S_PTR1: begin
          acc_q <= bwd_q ? mv_rd : r_rd;
          dv_q <= f_rd;
          lo_q <= ptr_rd;
          state_q <= S_PTR2;
        end
        S_PTR2: begin
          hi_q <= ptr_rd;
          j_q  <= bwd_q ? ptr_rd : lo_q;
          state_q <= S_ENT;
        end
        S_ENT: begin
          if ((!bwd_q && (i_q == 0 || j_q >= hi_q)) || (bwd_q && j_q <= lo_q))
            state_q <= S_DIAG;
          else state_q <= S_ENT2;
        end
        S_ENT2: begin
          col_q <= s_rd;
          if (!bwd_q) begin
            if (s_rd >= 13'(i_q)) state_q <= S_DIAG;
            else begin fv_q <= f_rd; state_q <= S_MAC1; end
          end else begin
            if (s_rd <= 13'(i_q)) state_q <= S_DIAG;
            else if (s_rd >= 13'(m)) begin j_q <= j_q - 1'b1; state_q <= S_ENT; end
            else begin fv_q <= f_rd; state_q <= S_MAC1; end
          end
        end
        S_MAC1: state_q <= S_MAC2;
        S_MAC2: begin
          acc_q <= mac_res;
          j_q <= bwd_q ? j_q - 1'b1 : j_q + 1'b1;
          state_q <= S_ENT;
        end
        S_DIAG: state_q <= S_DIAG2;
        S_DIAG2: begin
          if (!bwd_q) begin
            if (i_q + 1'b1 < (RowW+1)'(m)) begin i_q <= i_q + 1'b1; state_q <= S_ROW; end
            else if (mode_q == ModeFwd) begin copy_q <= 1'b1; i_q <= '0; state_q <= S_COPY; end
            else begin bwd_q <= 1'b1; i_q <= (RowW+1)'(m) - 1'b1; state_q <= S_ROW; end
          end else begin
            if (i_q == 0) state_q <= S_DONE;
            else begin i_q <= i_q - 1'b1; state_q <= S_ROW; end
          end
        end
        S_COPY: state_q <= S_COPY2;
        S_COPY2: begin
          if (i_q + 1'b1 < (RowW+1)'(m)) begin i_q <= i_q + 1'b1; state_q <= S_COPY; end
          else if (copy_q) state_q <= S_DONE;
          else begin bwd_q <= 1'b1; i_q <= (RowW+1)'(m) - 1'b1; state_q <= S_ROW; end
        end
        S_DONE: begin
          out_data_o.status <= 1'b1; out_valid_o <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  ap_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped");
  ap_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (out_valid_o && out_data_o.status))
    else $error("missing status");
endmodule
